[rtl/hufr_pkg.sv]
package hufr_pkg;

    localparam int unsigned POSITION_WIDTH_DEF = 24;
    localparam int unsigned REPORT_POS_W       = 24;

    localparam logic [7:0] SYNC_FIRST   = 8'h57;
    localparam logic [7:0] SYNC_SECOND  = 8'hAB;
    localparam logic [7:0] TYPE_STATUS  = 8'h80;
    localparam logic [7:0] TYPE_KEY     = 8'h01;
    localparam logic [7:0] TYPE_MOUSE   = 8'h04;
    localparam logic [7:0] SUB_MOUSE    = 8'h01;
    localparam logic [7:0] KEY_CAPS     = 8'h39;
    localparam logic [7:0] KEY_NUM      = 8'h53;
    localparam logic [7:0] TX_CMD       = 8'h12;
    localparam logic [7:0] TX_TAIL_0    = 8'h0F;
    localparam logic [7:0] TX_TAIL_1    = 8'h20;
    localparam logic [7:0] ROLLOVER_ARG = 8'hFF;
    localparam logic [7:0] LED_CAPS     = 8'h02;
    localparam logic [7:0] LED_NUM      = 8'h01;

    // frame position after the received byte is counted
    localparam logic [3:0] POS_STATUS = 4'd4;
    localparam logic [3:0] POS_MOUSE  = 4'd10;
    localparam logic [3:0] POS_KEY    = 4'd11;
    localparam logic [3:0] POS_STOP   = 4'd12;

    localparam logic [3:0] FRAME_LAST = 4'd10;

    localparam int WRAP_HALF = 512;
    localparam int WRAP_SPAN = 1024;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_MOUSE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        LOCK_OFF     = 2'd0,
        LOCK_ON_REQ  = 2'd1,
        LOCK_ON      = 2'd2,
        LOCK_OFF_REQ = 2'd3
    } t_lock;

    typedef enum logic {
        OP_RX      = 1'b0,
        OP_SET_POS = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         rx_byte;
        logic signed [23:0] set_x;
        logic signed [23:0] set_y;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         tx_byte;
        logic [7:0]         key_code;
        logic [7:0]         key_mod;
        logic               key_down;
        logic signed [23:0] mouse_x;
        logic signed [23:0] mouse_y;
        logic [7:0]         mouse_wheel;
        logic [7:0]         mouse_buttons;
        logic               last;
    } t_out_item;

    // work handed from the parser to the result sequencer
    typedef struct packed {
        logic               rpt_en;
        t_kind              rpt_kind;
        logic [7:0]         key_code;
        logic [7:0]         key_mod;
        logic               key_down;
        logic signed [23:0] mouse_x;
        logic signed [23:0] mouse_y;
        logic [7:0]         wheel;
        logic [7:0]         buttons;
        logic               frame_en;
        logic [7:0]         arg7;
        logic [7:0]         arg8;
    } t_job;

    function automatic logic [7:0] frame_byte(input logic [3:0] idx, input logic [7:0] arg7,
                                              input logic [7:0] arg8);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = SYNC_FIRST;
            4'd1:    b = SYNC_SECOND;
            4'd2:    b = TX_CMD;
            4'd7:    b = arg7;
            4'd8:    b = arg8;
            4'd9:    b = TX_TAIL_0;
            4'd10:   b = TX_TAIL_1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/hufr_chan_if.sv]
interface hufr_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/hufr_parse.sv]
module hufr_parse import hufr_pkg::*; #(
    parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hufr_chan_if.sink i_in,
    output logic      o_job_valid,
    output t_job      o_job,
    input  logic      i_job_ready
);

    localparam int PW = POSITION_WIDTH;
    localparam int WX = ((PW > 24) ? PW : 24) + 2;

    localparam logic signed [WX-1:0] P_HI   = {{(WX-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [WX-1:0] P_LO   = {{(WX-PW+1){1'b1}}, {(PW-1){1'b0}}};
    localparam logic signed [WX-1:0] W_HALF = WX'(WRAP_HALF);
    localparam logic signed [WX-1:0] W_SPAN = WX'(WRAP_SPAN);

    function automatic logic signed [PW-1:0] sat(input logic signed [WX-1:0] v);
        logic signed [PW-1:0] res;
        if (v > P_HI) begin
            res = P_HI[PW-1:0];
        end else if (v < P_LO) begin
            res = P_LO[PW-1:0];
        end else begin
            res = v[PW-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [WX-1:0] ext(input logic signed [PW-1:0] v);
        return {{(WX-PW){v[PW-1]}}, v};
    endfunction

    // returns {new offset, new position}
    function automatic logic [2*PW-1:0] unwrap(input logic signed [PW-1:0] pos,
                                               input logic signed [PW-1:0] off,
                                               input logic [9:0] act);
        logic signed [WX-1:0] a;
        logic signed [PW-1:0] no;
        logic signed [PW-1:0] np;
        a  = {{(WX-10){1'b0}}, act};
        no = off;
        if (ext(pos) - ext(no) > a + W_HALF) begin
            no = sat(ext(no) + W_SPAN);
        end
        if (ext(pos) - ext(no) < a - W_HALF) begin
            no = sat(ext(no) - W_SPAN);
        end
        np = sat(ext(no) + a);
        return {no, np};
    endfunction

    logic                 r_sync, n_sync;
    logic [3:0]           r_pos, n_pos;
    logic [7:0]           r_bytes [8];
    t_lock                r_caps, n_caps;
    t_lock                r_num, n_num;
    logic                 r_held, n_held;
    logic [7:0]           r_code, n_code;
    logic [7:0]           r_mod, n_mod;
    logic signed [PW-1:0] r_xoff, n_xoff, r_yoff, n_yoff;
    logic signed [PW-1:0] r_xpos, n_xpos, r_ypos, n_ypos;
    logic                 r_roll, n_roll;

    logic       acc_rx, acc_set;
    logic [7:0] c;
    logic       start;
    logic [3:0] p, np, wr_idx;
    logic       in_frame, wr_en;
    logic       at_status, at_key, at_mouse_pos, is_mouse, key_release;
    logic       lock_reply;
    logic [7:0] lock_arg;

    assign i_in.ready = i_job_ready;

    // decode
    always_comb begin
        acc_rx   = i_in.valid && i_job_ready && (i_in.data.op == OP_RX);
        acc_set  = i_in.valid && i_job_ready && (i_in.data.op == OP_SET_POS);
        c        = i_in.data.rx_byte;
        start    = (c == SYNC_SECOND) && r_sync;
        p        = start ? 4'd1 : r_pos;
        in_frame = (p != 4'd0) && (p < POS_STOP);
        np       = p + 4'd1;
        wr_idx   = p - 4'd1;
        wr_en    = acc_rx && in_frame && (wr_idx < 4'd8);
        at_status    = in_frame && (np == POS_STATUS) && (r_bytes[1] == TYPE_STATUS);
        at_key       = in_frame && (np == POS_KEY) && (r_bytes[1] == TYPE_KEY);
        at_mouse_pos = in_frame && (np == POS_MOUSE);
        is_mouse     = at_mouse_pos && (r_bytes[1] == TYPE_MOUSE) && (r_bytes[2] == SUB_MOUSE);
        key_release  = (r_bytes[3] == 8'h00) && (r_bytes[4] == 8'h00);

        lock_reply = 1'b1;
        lock_arg   = 8'h00;
        priority if (r_caps == LOCK_ON_REQ) begin
            lock_arg = LED_CAPS | ((r_num == LOCK_ON) ? LED_NUM : 8'h00);
        end else if (r_caps == LOCK_OFF_REQ) begin
            lock_arg = (r_num == LOCK_ON) ? LED_NUM : 8'h00;
        end else if (r_num == LOCK_ON_REQ) begin
            lock_arg = LED_NUM | ((r_caps == LOCK_ON) ? LED_CAPS : 8'h00);
        end else if (r_num == LOCK_OFF_REQ) begin
            lock_arg = (r_caps == LOCK_ON) ? LED_CAPS : 8'h00;
        end else begin
            lock_reply = 1'b0;
        end
    end

    // next state
    always_comb begin
        logic [2*PW-1:0]      ux, uy;
        logic signed [WX-1:0] dx, dy;
        logic signed [PW-1:0] nx, ny;
        n_sync = r_sync;
        n_pos  = r_pos;
        n_caps = r_caps;
        n_num  = r_num;
        n_held = r_held;
        n_code = r_code;
        n_mod  = r_mod;
        n_xoff = r_xoff;
        n_yoff = r_yoff;
        n_xpos = r_xpos;
        n_ypos = r_ypos;
        n_roll = r_roll;
        ux = unwrap(r_xpos, r_xoff, {r_bytes[5][1:0], r_bytes[4]});
        uy = unwrap(r_ypos, r_yoff, {r_bytes[7][1:0], r_bytes[6]});
        dx = ext(r_xpos) - ext(r_xoff);
        dy = ext(r_ypos) - ext(r_yoff);
        nx = sat({{(WX-24){i_in.data.set_x[23]}}, i_in.data.set_x});
        ny = sat({{(WX-24){i_in.data.set_y[23]}}, i_in.data.set_y});

        if (acc_set) begin
            // rebase offsets so that the relative motion is kept
            n_xoff = sat(ext(nx) - dx);
            n_yoff = sat(ext(ny) - dy);
            n_xpos = nx;
            n_ypos = ny;
        end

        if (acc_rx) begin
            n_sync = (c == SYNC_FIRST);
            n_pos  = p;
            if (in_frame) begin
                n_pos = np;
                if (at_status) begin
                    n_pos = 4'd0;
                    priority if (r_caps == LOCK_ON_REQ) begin
                        n_caps = LOCK_ON;
                    end else if (r_caps == LOCK_OFF_REQ) begin
                        n_caps = LOCK_OFF;
                    end else if (r_num == LOCK_ON_REQ) begin
                        n_num = LOCK_ON;
                    end else if (r_num == LOCK_OFF_REQ) begin
                        n_num = LOCK_OFF;
                    end else begin
                        n_caps = r_caps;
                    end
                end
                if (at_key) begin
                    if (key_release) begin
                        n_held = 1'b0;
                        n_code = 8'h00;
                    end else begin
                        if (r_bytes[4] == KEY_CAPS && !r_held && r_caps != LOCK_OFF_REQ) begin
                            n_caps = t_lock'(r_caps + 2'd1);
                        end
                        if (r_bytes[4] == KEY_NUM && !r_held && r_num != LOCK_OFF_REQ) begin
                            n_num = t_lock'(r_num + 2'd1);
                        end
                        n_code = r_bytes[4];
                        n_mod  = r_bytes[2];
                        n_held = 1'b1;
                    end
                end
                if (is_mouse) begin
                    n_xoff = ux[2*PW-1:PW];
                    n_xpos = ux[PW-1:0];
                    n_yoff = uy[2*PW-1:PW];
                    n_ypos = uy[PW-1:0];
                end
                if (at_mouse_pos) begin
                    n_roll = 1'b1;
                end
            end
        end
    end

    // job for the result sequencer
    always_comb begin
        logic signed [WX-1:0] mx, my;
        logic                 roll_now;
        mx       = ext(n_xpos);
        my       = ext(n_ypos);
        roll_now = at_mouse_pos && !r_roll;

        o_job          = '0;
        o_job.rpt_kind = is_mouse ? KIND_MOUSE : KIND_KEY;
        o_job.rpt_en   = at_key || is_mouse;
        o_job.key_code = n_code;
        o_job.key_mod  = n_mod;
        o_job.key_down = n_held;
        o_job.mouse_x  = mx[REPORT_POS_W-1:0];
        o_job.mouse_y  = my[REPORT_POS_W-1:0];
        o_job.wheel    = c;
        o_job.buttons  = r_bytes[3];
        o_job.frame_en = (at_status && lock_reply) || roll_now;
        o_job.arg7     = at_status ? lock_arg : ROLLOVER_ARG;
        o_job.arg8     = at_status ? c : ROLLOVER_ARG;
        o_job_valid    = acc_rx && (o_job.rpt_en || o_job.frame_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= 1'b0;
            r_pos  <= 4'd0;
            r_caps <= LOCK_OFF;
            r_num  <= LOCK_OFF;
            r_held <= 1'b0;
            r_code <= 8'h00;
            r_mod  <= 8'h00;
            r_xoff <= '0;
            r_yoff <= '0;
            r_xpos <= '0;
            r_ypos <= '0;
            r_roll <= 1'b0;
        end else begin
            r_sync <= n_sync;
            r_pos  <= n_pos;
            r_caps <= n_caps;
            r_num  <= n_num;
            r_held <= n_held;
            r_code <= n_code;
            r_mod  <= n_mod;
            r_xoff <= n_xoff;
            r_yoff <= n_yoff;
            r_xpos <= n_xpos;
            r_ypos <= n_ypos;
            r_roll <= n_roll;
        end
    end

    // frame store: entries are always written within a frame before use
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bytes[wr_idx[2:0]] <= c;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_STOP)
        else $error("frame position past stop");

    a_job_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> i_job_ready)
        else $error("job raised while sequencer busy");

endmodule

[rtl/hufr_emit.sv]
module hufr_emit import hufr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_ready,
    hufr_chan_if.source o_out
);

    logic       r_job_valid, n_job_valid;
    t_job       r_job, n_job;
    logic       r_rpt_pend, n_rpt_pend;
    logic [3:0] r_fidx, n_fidx;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    t_out_item item;
    logic      adv, job_done;

    // current item of the job
    always_comb begin
        item = '0;
        if (r_rpt_pend) begin
            item.kind = r_job.rpt_kind;
            if (r_job.rpt_kind == KIND_MOUSE) begin
                item.mouse_x       = r_job.mouse_x;
                item.mouse_y       = r_job.mouse_y;
                item.mouse_wheel   = r_job.wheel;
                item.mouse_buttons = r_job.buttons;
            end else begin
                item.key_code = r_job.key_code;
                item.key_mod  = r_job.key_mod;
                item.key_down = r_job.key_down;
            end
            item.last = !r_job.frame_en;
        end else begin
            item.kind    = KIND_TX;
            item.tx_byte = frame_byte(r_fidx, r_job.arg7, r_job.arg8);
            item.last    = (r_fidx == FRAME_LAST);
        end
        adv         = r_job_valid && (!r_out_valid || o_out.ready);
        job_done    = adv && item.last;
        o_job_ready = !r_job_valid || job_done;
    end

    always_comb begin
        n_job_valid = r_job_valid;
        n_job       = r_job;
        n_rpt_pend  = r_rpt_pend;
        n_fidx      = r_fidx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        if (adv) begin
            n_out       = item;
            n_out_valid = 1'b1;
            if (r_rpt_pend) begin
                n_rpt_pend = 1'b0;
            end else begin
                n_fidx = r_fidx + 4'd1;
            end
        end
        if (job_done) begin
            n_job_valid = 1'b0;
        end
        // load the next job while the last item of this one goes out
        if (i_job_valid && o_job_ready) begin
            n_job       = i_job;
            n_job_valid = 1'b1;
            n_rpt_pend  = i_job.rpt_en;
            n_fidx      = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_rpt_pend  <= 1'b0;
            r_fidx      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            r_rpt_pend  <= n_rpt_pend;
            r_fidx      <= n_fidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_rpt_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rpt_pend |-> r_job_valid)
        else $error("report pending without a job");

    a_fidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_fidx <= FRAME_LAST))
        else $error("frame index past last byte");

    a_job_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && o_job_ready) |=> (r_job_valid && r_fidx == 4'd0))
        else $error("job not loaded at start");

endmodule

[rtl/hid_uart_frame_receiver.sv]
// An accepted item's results pass through the job register and then the output register.
// Throughput: one item per cycle while the result sequencer is free; an item with
// k results (k up to 12: an 11-byte reply frame plus one report) holds it, sending
// one result per cycle while o_out is ready, and takes the next item with its last.
// Reset: synchronous active-low i_rst_n clears sync, frame, lock, key and position
// state and empties the job and output stages.
module hid_uart_frame_receiver import hufr_pkg::*; #(
    parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hufr_chan_if.sink   i_in,
    hufr_chan_if.source o_out
);

    logic job_valid;
    logic job_ready;
    t_job job;

    hufr_parse #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_job_valid(job_valid),
        .o_job      (job),
        .i_job_ready(job_ready)
    );

    hufr_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(job_valid),
        .i_job      (job),
        .o_job_ready(job_ready),
        .o_out      (o_out)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import hufr_pkg::*;

    localparam int          PW           = POSITION_WIDTH_DEF;
    localparam longint      POS_MAX      = (longint'(1) << (PW - 1)) - 1;
    localparam longint      POS_MIN      = -POS_MAX - 1;
    localparam int          RAND_ITEMS   = 480;
    localparam int          CALM_ITEMS   = 50;
    localparam int          HOLD_AFTER   = 200;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct {
        t_in_item  it;
        int        n_typed;   // -1: take the results from the decoder
        t_out_item res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    hufr_chan_if #(.T(t_in_item))  in_ch ();
    hufr_chan_if #(.T(t_out_item)) out_ch ();

    hid_uart_frame_receiver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    t_stim_row stim_rows[$];
    t_out_item decoded_now[$];
    t_out_item due_results[$];

    int  fails     = 0;
    int  items_in  = 0;
    int  n_tx      = 0;
    int  n_key     = 0;
    int  n_mouse   = 0;
    bit  calm      = 1'b0;
    bit  hold_done = 1'b0;

    // bridge decoder state
    logic                 sync_armed    = 1'b0;
    logic [3:0]           fpos          = 4'd0;
    logic [7:0]           fbuf [0:10];
    t_lock                caps_lk       = LOCK_OFF;
    t_lock                num_lk        = LOCK_OFF;
    logic                 key_is_held   = 1'b0;
    logic [7:0]           hold_code     = 8'h00;
    logic [7:0]           hold_mod      = 8'h00;
    logic signed [PW-1:0] x_off         = '0;
    logic signed [PW-1:0] y_off         = '0;
    logic signed [PW-1:0] x_pos         = '0;
    logic signed [PW-1:0] y_pos         = '0;
    logic                 rollover_done = 1'b0;

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic void queue_reply(input logic [7:0] b7, input logic [7:0] b8);
        logic [7:0] fr [0:10];
        t_out_item  r;
        fr = '{SYNC_FIRST, SYNC_SECOND, TX_CMD, 8'h00, 8'h00, 8'h00, 8'h00, b7, b8,
               TX_TAIL_0, TX_TAIL_1};
        foreach (fr[i]) begin
            r = '0;
            r.kind = KIND_TX;
            r.tx_byte = fr[i];
            decoded_now.push_back(r);
        end
    endfunction

    // move the offset by one wrap span when the raw count jumped across the window
    function automatic void unwrap_axis(inout logic signed [PW-1:0] pos,
                                        inout logic signed [PW-1:0] off,
                                        input longint act);
        longint p;
        longint o;
        longint q;
        p = longint'(pos);
        o = longint'(off);
        if (p - o > act + WRAP_HALF) o = clamp_pos(o + WRAP_SPAN);
        if (p - o < act - WRAP_HALF) o = clamp_pos(o - WRAP_SPAN);
        q = clamp_pos(o + act);
        off = o[PW-1:0];
        pos = q[PW-1:0];
    endfunction

    task automatic frame_decode(input t_in_item it);
        logic [7:0] c;
        logic [7:0] st;
        longint     dx;
        longint     dy;
        longint     nx;
        longint     ny;
        longint     ax;
        longint     ay;
        t_out_item  r;
        decoded_now.delete();
        if (it.op == OP_SET_POS) begin
            dx = longint'(x_pos) - longint'(x_off);
            dy = longint'(y_pos) - longint'(y_off);
            nx = clamp_pos(longint'(it.set_x));
            ny = clamp_pos(longint'(it.set_y));
            dx = clamp_pos(nx - dx);
            dy = clamp_pos(ny - dy);
            x_off = dx[PW-1:0];
            y_off = dy[PW-1:0];
            x_pos = nx[PW-1:0];
            y_pos = ny[PW-1:0];
            return;
        end
        c = it.rx_byte;
        if (c == SYNC_FIRST) begin
            sync_armed = 1'b1;
        end else if (c == SYNC_SECOND && sync_armed) begin
            sync_armed = 1'b0;
            fpos = 4'd1;
        end else begin
            sync_armed = 1'b0;
        end
        if (fpos > 4'd0 && fpos < POS_STOP) begin
            fbuf[fpos - 4'd1] = c;
            fpos = fpos + 4'd1;
            if (fpos == POS_STATUS && fbuf[1] == TYPE_STATUS) begin
                st = fbuf[2];
                if (caps_lk == LOCK_ON_REQ) begin
                    queue_reply(LED_CAPS | ((num_lk == LOCK_ON) ? LED_NUM : 8'h00), st);
                    caps_lk = LOCK_ON;
                end else if (caps_lk == LOCK_OFF_REQ) begin
                    queue_reply((num_lk == LOCK_ON) ? LED_NUM : 8'h00, st);
                    caps_lk = LOCK_OFF;
                end else if (num_lk == LOCK_ON_REQ) begin
                    queue_reply(LED_NUM | ((caps_lk == LOCK_ON) ? LED_CAPS : 8'h00), st);
                    num_lk = LOCK_ON;
                end else if (num_lk == LOCK_OFF_REQ) begin
                    queue_reply((caps_lk == LOCK_ON) ? LED_CAPS : 8'h00, st);
                    num_lk = LOCK_OFF;
                end
                fpos = 4'd0;
            end
            if (fpos == POS_KEY && fbuf[1] == TYPE_KEY) begin
                if (fbuf[3] == 8'h00 && fbuf[4] == 8'h00) begin
                    key_is_held = 1'b0;
                    hold_code = 8'h00;
                end else begin
                    // count lock presses on the first frame of a press only
                    if (fbuf[4] == KEY_CAPS && !key_is_held && caps_lk != LOCK_OFF_REQ)
                        caps_lk = t_lock'(caps_lk + 2'd1);
                    if (fbuf[4] == KEY_NUM && !key_is_held && num_lk != LOCK_OFF_REQ)
                        num_lk = t_lock'(num_lk + 2'd1);
                    hold_code = fbuf[4];
                    hold_mod = fbuf[2];
                    key_is_held = 1'b1;
                end
                r = '0;
                r.kind = KIND_KEY;
                r.key_code = hold_code;
                r.key_mod = hold_mod;
                r.key_down = key_is_held;
                decoded_now.push_back(r);
            end
            if (fpos == POS_MOUSE) begin
                if (fbuf[1] == TYPE_MOUSE && fbuf[2] == SUB_MOUSE) begin
                    ax = longint'({fbuf[5][1:0], fbuf[4]});
                    ay = longint'({fbuf[7][1:0], fbuf[6]});
                    unwrap_axis(x_pos, x_off, ax);
                    unwrap_axis(y_pos, y_off, ay);
                    r = '0;
                    r.kind = KIND_MOUSE;
                    r.mouse_x = x_pos[REPORT_POS_W-1:0];
                    r.mouse_y = y_pos[REPORT_POS_W-1:0];
                    r.mouse_wheel = fbuf[8];
                    r.mouse_buttons = fbuf[3];
                    decoded_now.push_back(r);
                end
                if (!rollover_done) begin
                    queue_reply(ROLLOVER_ARG, ROLLOVER_ARG);
                    rollover_done = 1'b1;
                end
            end
        end
        if (decoded_now.size() > 0) decoded_now[$].last = 1'b1;
    endtask

    function automatic void add_row(input t_op op, input logic [7:0] b,
                                    input logic signed [23:0] sx,
                                    input logic signed [23:0] sy,
                                    input int n_typed, input t_out_item res);
        t_stim_row row;
        row.it.op = op;
        row.it.rx_byte = b;
        row.it.set_x = sx;
        row.it.set_y = sy;
        row.n_typed = n_typed;
        row.res = res;
        stim_rows.push_back(row);
    endfunction

    function automatic void put_rx(input logic [7:0] b);
        add_row(OP_RX, b, 24'($urandom), 24'($urandom), -1, '0);
    endfunction

    task automatic offer(input int idx);
        int        gap;
        t_stim_row row;
        row = stim_rows[idx];
        calm = (idx >= stim_rows.size() - CALM_ITEMS);
        // every third block of 40 items goes without sender gaps
        if (!calm && ((idx / 40) % 3 != 0) && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= row.it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        frame_decode(row.it);
        if (row.n_typed < 0) begin
            foreach (decoded_now[i]) due_results.push_back(decoded_now[i]);
        end else if (row.n_typed == 1) begin
            due_results.push_back(row.res);
        end
        items_in++;
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            case (got.kind)
                KIND_TX:    n_tx++;
                KIND_KEY:   n_key++;
                KIND_MOUSE: n_mouse++;
                default:    ;
            endcase
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fails++;
            end else begin
                want = due_results.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("key_code", want.key_code, got.key_code);
                check_field("key_mod", want.key_mod, got.key_mod);
                check_field("key_down", want.key_down, got.key_down);
                check_field("mouse_x", want.mouse_x, got.mouse_x);
                check_field("mouse_y", want.mouse_y, got.mouse_y);
                check_field("mouse_wheel", want.mouse_wheel, got.mouse_wheel);
                check_field("mouse_buttons", want.mouse_buttons, got.mouse_buttons);
                check_field("last", want.last, got.last);
            end
        end
    end

    initial begin : result_sink
        int len;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!hold_done && items_in >= HOLD_AFTER) begin
                // hold off long enough for the block to back up into its input
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                len = $urandom_range(1, 13);
                repeat (len) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 12);
                repeat (len) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
        $display("tb: failure");
        $finish;
    end

    initial begin : main_seq
        t_out_item  nil;
        t_out_item  caps_rpt;
        int         pick;
        int         k;
        int         n;
        logic [7:0] code;
        logic [7:0] b3;
        logic [7:0] ftype;
        logic [23:0] px;
        logic [23:0] py;

        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        foreach (fbuf[i]) fbuf[i] = 8'h00;

        nil = '0;
        caps_rpt = '0;
        caps_rpt.kind = KIND_KEY;
        caps_rpt.key_code = KEY_CAPS;
        caps_rpt.key_mod = 8'h02;
        caps_rpt.key_down = 1'b1;
        caps_rpt.last = 1'b1;

        //       op          byte         set_x          set_y        typed  result
        add_row(OP_SET_POS, 8'h00,       24'sh7FFFFF, 24'sh800000,  0, nil);
        add_row(OP_SET_POS, 8'hFF,       24'sh800000, 24'sh7FFFFF,  0, nil);
        add_row(OP_SET_POS, 8'h00,       24'sh000000, 24'sh000000,  0, nil);
        add_row(OP_RX,      SYNC_SECOND, 24'sh0,      24'sh0,       0, nil);
        // doubled sync byte still arms, then an idle status frame ends without a reply
        add_row(OP_RX,      SYNC_FIRST,  24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      SYNC_FIRST,  24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      SYNC_SECOND, 24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      TYPE_STATUS, 24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      8'hFF,       24'sh0,      24'sh0,       0, nil);
        // caps press: rollover frame on the tenth byte, key report on the eleventh
        add_row(OP_RX,      SYNC_FIRST,  24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      SYNC_SECOND, 24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      TYPE_KEY,    24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      8'h02,       24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      8'h00,       24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      KEY_CAPS,    24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      8'h00,       24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      8'h00,       24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      8'h00,       24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      8'h00,       24'sh0,      24'sh0,      -1, nil);
        add_row(OP_RX,      8'h00,       24'sh0,      24'sh0,       1, caps_rpt);
        // pending caps change answers the next status frame with an LED frame
        add_row(OP_RX,      SYNC_FIRST,  24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      SYNC_SECOND, 24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      TYPE_STATUS, 24'sh0,      24'sh0,       0, nil);
        add_row(OP_RX,      8'h5A,       24'sh0,      24'sh0,      -1, nil);

        n = stim_rows.size();
        while (stim_rows.size() < n + RAND_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                put_rx(SYNC_FIRST);
                put_rx(SYNC_SECOND);
                put_rx(TYPE_STATUS);
                put_rx(8'($urandom));
            end else if (pick < 9) begin
                k = $urandom_range(0, 9);
                b3 = 8'($urandom);
                if (k < 3) begin
                    b3 = 8'h00;
                    code = 8'h00;
                end else if (k < 5) begin
                    code = KEY_CAPS;
                end else if (k < 7) begin
                    code = KEY_NUM;
                end else begin
                    code = 8'($urandom);
                end
                put_rx(SYNC_FIRST);
                put_rx(SYNC_SECOND);
                put_rx(TYPE_KEY);
                put_rx(8'($urandom));
                put_rx(b3);
                put_rx(code);
                repeat (5) put_rx(8'($urandom));
                if ($urandom_range(0, 4) == 0) put_rx(8'($urandom));
            end else if (pick < 15) begin
                put_rx(SYNC_FIRST);
                put_rx(SYNC_SECOND);
                put_rx(TYPE_MOUSE);
                put_rx(($urandom_range(0, 9) == 0) ? 8'($urandom) : SUB_MOUSE);
                repeat (6) put_rx(8'($urandom));
                k = $urandom_range(0, 3);
                if (k < 2) repeat (k + 1) put_rx(8'($urandom));
            end else if (pick == 15) begin
                // overlong frame: bytes past the stop position are dropped
                ftype = $urandom_range(0, 1) ? TYPE_KEY : 8'($urandom);
                if (ftype == TYPE_STATUS) ftype = TYPE_MOUSE;
                put_rx(SYNC_FIRST);
                put_rx(SYNC_SECOND);
                put_rx(ftype);
                repeat ($urandom_range(11, 15)) put_rx(8'($urandom));
            end else if (pick == 16) begin
                // cut-off frame; the next sync pair restarts it
                put_rx(SYNC_FIRST);
                put_rx(SYNC_SECOND);
                put_rx($urandom_range(0, 1) ? TYPE_KEY : TYPE_MOUSE);
                repeat ($urandom_range(0, 6)) put_rx(8'($urandom));
            end else if (pick == 17) begin
                repeat ($urandom_range(1, 5)) begin
                    k = $urandom_range(0, 3);
                    put_rx((k == 0) ? SYNC_FIRST : (k == 1) ? SYNC_SECOND : 8'($urandom));
                end
            end else begin
                k = $urandom_range(0, 3);
                px = (k == 0) ? 24'h7FFFFF : (k == 1) ? 24'h800000 :
                     (k == 2) ? 24'(24'h7FFFFF - $urandom_range(0, 1500)) : 24'($urandom);
                k = $urandom_range(0, 3);
                py = (k == 0) ? 24'h7FFFFF : (k == 1) ? 24'h800000 :
                     (k == 2) ? 24'(24'h800000 + $urandom_range(0, 1500)) : 24'($urandom);
                add_row(OP_SET_POS, 8'($urandom), px, py, -1, nil);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < stim_rows.size(); i++) offer(i);
        in_ch.valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input items: %0d reply bytes, %0d key and %0d mouse reports",
                 items_in, n_tx, n_key, n_mouse);
        $display("with sync restarts, overlong frames, lock toggling and position clamping");
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/hufr_pkg.sv
rtl/hufr_chan_if.sv
rtl/hufr_parse.sv
rtl/hufr_emit.sv
rtl/hid_uart_frame_receiver.sv
dv/tb.sv
